// ===== rtl/stt_pkg.sv =====
// shared types, constants and codes for the software timer table
`default_nettype none
package stt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int MS_TO_NS = 1000000;
  localparam int FS_PER_NS_DIV = 1000000;
  localparam logic [26:0] PERIOD_RESET = 27'd69841279;

  localparam int CNT_W = 48;
  localparam int PERIOD_W = 27;
  localparam int TICKS_W = 20;
  localparam int ID_W = 32;
  localparam int NOW_W = 55;
  localparam int DL_W = 56;
  localparam int IVAL_W = 40;
  localparam int HALF_W = 24;
  localparam int PP_W = HALF_W + PERIOD_W;
  localparam int PROD_W = CNT_W + PERIOD_W;
  localparam int REM_W = 20;

  // divide by 1000000 in 16-bit quotient digits
  localparam int ACC_W = 80;
  localparam int DIG_W = 16;
  localparam int DIV_DIGITS = ACC_W / DIG_W;
  localparam int PART_W = REM_W + DIG_W;
  localparam int FS_SHIFT = 6;
  localparam int EST_W = PART_W - FS_SHIFT;
  // ceil(2^44 / 15625), exact quotient for every 30-bit operand
  localparam int RECIP_W = 31;
  localparam logic [30:0] RECIP_K = 31'd1125899907;
  localparam int RECIP_SH = 44;

  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 88;

  typedef enum logic [1:0] {
    OP_CHECK,
    OP_ADD_ONE,
    OP_ADD_PER,
    OP_CANCEL
  } op_t;

  typedef enum logic [2:0] {
    KIND_FIRED,
    KIND_CHECK_DONE,
    KIND_ADDED,
    KIND_FULL,
    KIND_CANCEL_DONE
  } kind_t;

  typedef struct packed {
    logic [DL_W-1:0]   deadline;
    logic [IVAL_W-1:0] interval;
    logic              periodic;
    logic [ID_W-1:0]   ident;
  } entry_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic mul_acc;
    logic div_est;
    logic div_step;
    logic latch_now;
    logic scan_init;
    logic rd;
    logic ev;
    logic add;
    logic fin;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic div_last;
    logic empty;
    logic more;
    logic ev_stall;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/software_timer_table.sv =====
// top level of the software timer table
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata, tuser (op)
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata, tuser (kind), tlast
//  apb       in   psel/penable/pready            paddr, pwdata, prdata
// an add or a scan of an empty table goes through acceptance, the counter times
// period product, the divide by 1000000 (five 16-bit quotient digits, estimate
// then subtract), latching the time, dispatch and the result. a check or cancel
// reads each of the n entries through the registered table read before the result.
// a fired or final result waits while m_axis holds the result register.
// rst is synchronous and clears the period, table count, id source and result
// valid; table contents are not cleared.
`default_nettype none
module software_timer_table #(
  parameter int TABLE_DEPTH = stt_pkg::TABLE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output      logic          s_axis_tready,
  input  wire logic [103:0]  s_axis_tdata,  // counter_value, interval_ticks, cancel_id
  input  wire logic [1:0]    s_axis_tuser,  // op
  output      logic          m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output      logic [87:0]   m_axis_tdata,  // timer_id, was_periodic, now_ns
  output      logic [2:0]    m_axis_tuser,  // kind
  output      logic          m_axis_tlast,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output      logic [31:0]   prdata,
  output      logic          pready
);
  logic [stt_pkg::PERIOD_W-1:0] period;
  stt_pkg::cmd_t cmd;
  stt_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(period);

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= stt_pkg::PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      period <= pwdata[stt_pkg::PERIOD_W-1:0];
    end
  end

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .period    (period),
    .in_tdata  (s_axis_tdata),
    .in_tuser  (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tdata (m_axis_tdata),
    .out_tuser (m_axis_tuser),
    .out_tlast (m_axis_tlast)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == stt_pkg::KIND_FIRED |-> !m_axis_tlast)
    else $error("fired transaction marked last");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == stt_pkg::KIND_CHECK_DONE |-> m_axis_tlast)
    else $error("check done transaction not marked last");
endmodule
`default_nettype wire

// ===== rtl/stt_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output      logic [WIDTH-1:0]       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/stt_ctrl.sv =====
// controller state machine of the software timer table
`default_nettype none
module stt_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output      logic         in_ready,
  input  wire stt_pkg::sts_t sts,
  output      stt_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_DIVQ, S_DIV, S_NOW, S_DISP, S_RD, S_EV, S_FIN, S_ADD
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_acc = 1'b1;
        state_next = S_DIVQ;
      end
      S_DIVQ: begin
        cmd.div_est = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next = sts.div_last ? S_NOW : S_DIVQ;
      end
      S_NOW: begin
        cmd.latch_now = 1'b1;
        cmd.scan_init = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        if (sts.op inside {stt_pkg::OP_ADD_ONE, stt_pkg::OP_ADD_PER}) begin
          state_next = S_ADD;
        end else if (sts.empty) begin
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_EV;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        if (!sts.ev_stall) begin
          cmd.ev = 1'b1;
          state_next = sts.more ? S_RD : S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.add = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/stt_dp.sv =====
// datapath: time conversion, timer table scan and result register
`default_nettype none
module stt_dp #(
  parameter int TABLE_DEPTH = stt_pkg::TABLE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire stt_pkg::cmd_t                    cmd,
  output      stt_pkg::sts_t                    sts,
  input  wire logic [stt_pkg::PERIOD_W-1:0]     period,
  input  wire logic [stt_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [1:0]                       in_tuser,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [stt_pkg::OUT_DATA_W-1:0]   out_tdata,
  output      logic [2:0]                       out_tuser,
  output      logic                             out_tlast
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(stt_pkg::entry_t);
  localparam int EP_W = stt_pkg::EST_W + stt_pkg::RECIP_W;
  localparam logic [stt_pkg::IVAL_W-1:0] RATE_K = stt_pkg::IVAL_W'(stt_pkg::MS_TO_NS);
  localparam logic [stt_pkg::PART_W-1:0] DIV_K = stt_pkg::PART_W'(stt_pkg::FS_PER_NS_DIV);
  localparam logic [EP_W-1:0] RECIP_K = EP_W'(stt_pkg::RECIP_K);
  localparam logic [2:0] DIV_LAST = 3'(stt_pkg::DIV_DIGITS - 1);

  stt_pkg::op_t                    op;
  logic [stt_pkg::CNT_W-1:0]       counter;
  logic [stt_pkg::IVAL_W-1:0]      ival;
  logic [stt_pkg::ID_W-1:0]        cid;
  logic [stt_pkg::PP_W-1:0]        pp;
  logic [stt_pkg::ACC_W-1:0]       acc;
  logic [stt_pkg::REM_W-1:0]       rem;
  logic [stt_pkg::DIG_W-1:0]       qd;
  logic [2:0]                      div_cnt;
  logic [stt_pkg::NOW_W-1:0]       now;
  logic [CW-1:0]                   ridx;
  logic [CW-1:0]                   widx;
  logic [CW-1:0]                   count;
  logic [stt_pkg::ID_W-1:0]        next_id;

  logic [stt_pkg::PART_W-1:0]      part;
  logic [EP_W-1:0]                 est_prod;
  logic [stt_pkg::PART_W-1:0]      qd_mul;
  logic [stt_pkg::PART_W-1:0]      part_rem;
  stt_pkg::entry_t                 rd_entry;
  stt_pkg::entry_t                 wr_entry;
  logic [EW-1:0]                   rdata;
  logic                            we;
  logic [IW-1:0]                   waddr;
  logic [stt_pkg::DL_W-1:0]        now_ext;
  logic [stt_pkg::DL_W-1:0]        rearm;
  logic                            fire;
  logic                            keep;
  logic                            is_check;
  logic                            full;
  logic [CW:0]                     ridx_inc;

  assign part = {rem, acc[stt_pkg::ACC_W-1 -: stt_pkg::DIG_W]};
  assign est_prod = EP_W'(part[stt_pkg::PART_W-1:stt_pkg::FS_SHIFT]) * RECIP_K;
  assign qd_mul = stt_pkg::PART_W'(qd) * DIV_K;
  assign part_rem = part - qd_mul;
  assign rd_entry = stt_pkg::entry_t'(rdata);
  assign now_ext = {1'b0, now};
  assign rearm = now_ext + stt_pkg::DL_W'(rd_entry.interval);
  assign is_check = (op == stt_pkg::OP_CHECK);
  assign fire = is_check && (rd_entry.deadline < now_ext);
  assign keep = is_check ? (!fire || rd_entry.periodic) : (rd_entry.ident != cid);
  assign full = (count == CW'(TABLE_DEPTH));
  assign ridx_inc = {1'b0, ridx} + (CW + 1)'(1);

  always_comb begin
    we = 1'b0;
    waddr = widx[IW-1:0];
    wr_entry = rd_entry;
    if (is_check && fire) begin
      wr_entry.deadline = rearm;
    end
    if (cmd.ev && keep) begin
      we = 1'b1;
    end
    if (cmd.add && !full) begin
      we = 1'b1;
      waddr = count[IW-1:0];
      wr_entry.deadline = now_ext + stt_pkg::DL_W'(ival);
      wr_entry.interval = ival;
      wr_entry.periodic = (op == stt_pkg::OP_ADD_PER);
      wr_entry.ident = next_id;
    end
  end

  stt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (cmd.rd),
    .raddr (ridx[IW-1:0]),
    .rdata (rdata)
  );

  assign sts.op = op;
  assign sts.div_last = (div_cnt == DIV_LAST);
  assign sts.empty = (count == '0);
  assign sts.more = (ridx_inc < {1'b0, count});
  assign sts.out_free = !out_valid || out_ready;
  assign sts.ev_stall = fire && out_valid && !out_ready;

  // time conversion and scan datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= stt_pkg::op_t'(in_tuser);
      counter <= in_tdata[47:0];
      ival <= stt_pkg::IVAL_W'(in_tdata[67:48]) * RATE_K;
      cid <= in_tdata[99:68];
    end
    if (cmd.mul_lo) begin
      pp <= stt_pkg::PP_W'(counter[stt_pkg::HALF_W-1:0]) * stt_pkg::PP_W'(period);
    end
    if (cmd.mul_hi) begin
      acc <= stt_pkg::ACC_W'(pp);
      pp <= stt_pkg::PP_W'(counter[stt_pkg::CNT_W-1:stt_pkg::HALF_W]) * stt_pkg::PP_W'(period);
    end
    if (cmd.mul_acc) begin
      acc <= acc + stt_pkg::ACC_W'({pp, {stt_pkg::HALF_W{1'b0}}});
      rem <= '0;
      div_cnt <= '0;
    end
    // quotient digit estimate: floor(part / 64) * ceil(2^44 / 15625) >> 44
    if (cmd.div_est) begin
      qd <= est_prod[stt_pkg::RECIP_SH +: stt_pkg::DIG_W];
    end
    if (cmd.div_step) begin
      rem <= part_rem[stt_pkg::REM_W-1:0];
      acc <= {acc[stt_pkg::ACC_W-stt_pkg::DIG_W-1:0], qd};
      div_cnt <= div_cnt + 3'd1;
    end
    if (cmd.latch_now) begin
      now <= (|acc[stt_pkg::ACC_W-1:stt_pkg::NOW_W]) ? '1 : acc[stt_pkg::NOW_W-1:0];
    end
    if (cmd.scan_init) begin
      ridx <= '0;
      widx <= '0;
    end
    if (cmd.ev) begin
      ridx <= ridx_inc[CW-1:0];
      if (keep) begin
        widx <= widx + CW'(1);
      end
    end
  end

  // table count, id source and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      next_id <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.ev && fire) begin
        out_valid <= 1'b1;
        out_tuser <= stt_pkg::KIND_FIRED;
        out_tdata <= {now, rd_entry.periodic, rd_entry.ident};
        out_tlast <= 1'b0;
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
        out_tlast <= 1'b1;
        count <= widx;
        if (is_check) begin
          out_tuser <= stt_pkg::KIND_CHECK_DONE;
          out_tdata <= {now, 1'b0, {stt_pkg::ID_W{1'b0}}};
        end else begin
          out_tuser <= stt_pkg::KIND_CANCEL_DONE;
          out_tdata <= {now, 1'b0, cid};
        end
      end
      if (cmd.add) begin
        out_valid <= 1'b1;
        out_tlast <= 1'b1;
        if (full) begin
          out_tuser <= stt_pkg::KIND_FULL;
          out_tdata <= {now, 1'b0, {stt_pkg::ID_W{1'b1}}};
        end else begin
          out_tuser <= stt_pkg::KIND_ADDED;
          out_tdata <= {now, (op == stt_pkg::OP_ADD_PER), next_id};
          count <= count + CW'(1);
          next_id <= next_id + 32'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire
